// File: hdl/zuc_pkg.sv
// Shared types, constants and round functions for the ZUC-128 keystream generator.
// S-boxes, key-loading constants, L1/L2 and the mod 2^31-1 adder live here.
// No dependencies; used by zuc_lfsr, zuc_nlf and the top level.
package zuc_pkg;

    typedef logic [30:0]       t_cell;
    typedef logic [15:0][30:0] t_cells;

    localparam int unsigned NUM_CELLS   = 16;
    localparam logic [5:0]  INIT_ROUNDS = 6'd32;

    localparam logic OP_INIT = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_IV_HIGH  = 2'd2,
        CFG_IV_LOW   = 2'd3
    } t_cfg_reg;

    // LFSR feedback terms, folded in one per cycle
    typedef enum logic [2:0] {
        TAP_C0  = 3'd0,
        TAP_C4  = 3'd1,
        TAP_C10 = 3'd2,
        TAP_C13 = 3'd3,
        TAP_C15 = 3'd4
    } t_tap;

    typedef struct packed {
        logic load;   // load cells from key, d and IV
        logic start;  // seed accumulator with cell 0
        logic add;    // fold the selected tap
        logic feed;   // fold the extra term and shift
        t_tap tap;
    } t_lfsr_ctl;

    typedef struct packed {
        logic clear;  // zero R1 and R2
        logic step;   // advance R1/R2 and hold W
    } t_nlf_ctl;

    localparam logic [14:0] DCONST [16] = '{
        15'h44D7, 15'h26BC, 15'h626B, 15'h135E, 15'h5789, 15'h35E2, 15'h7135, 15'h09AF,
        15'h4D78, 15'h2F13, 15'h6BC4, 15'h1AF1, 15'h5E26, 15'h3C4D, 15'h789A, 15'h47AC
    };

    localparam logic [7:0] SBOX0 [256] = '{
        8'h3e,8'h72,8'h5b,8'h47,8'hca,8'he0,8'h00,8'h33,8'h04,8'hd1,8'h54,8'h98,8'h09,8'hb9,8'h6d,8'hcb,
        8'h7b,8'h1b,8'hf9,8'h32,8'haf,8'h9d,8'h6a,8'ha5,8'hb8,8'h2d,8'hfc,8'h1d,8'h08,8'h53,8'h03,8'h90,
        8'h4d,8'h4e,8'h84,8'h99,8'he4,8'hce,8'hd9,8'h91,8'hdd,8'hb6,8'h85,8'h48,8'h8b,8'h29,8'h6e,8'hac,
        8'hcd,8'hc1,8'hf8,8'h1e,8'h73,8'h43,8'h69,8'hc6,8'hb5,8'hbd,8'hfd,8'h39,8'h63,8'h20,8'hd4,8'h38,
        8'h76,8'h7d,8'hb2,8'ha7,8'hcf,8'hed,8'h57,8'hc5,8'hf3,8'h2c,8'hbb,8'h14,8'h21,8'h06,8'h55,8'h9b,
        8'he3,8'hef,8'h5e,8'h31,8'h4f,8'h7f,8'h5a,8'ha4,8'h0d,8'h82,8'h51,8'h49,8'h5f,8'hba,8'h58,8'h1c,
        8'h4a,8'h16,8'hd5,8'h17,8'ha8,8'h92,8'h24,8'h1f,8'h8c,8'hff,8'hd8,8'hae,8'h2e,8'h01,8'hd3,8'had,
        8'h3b,8'h4b,8'hda,8'h46,8'heb,8'hc9,8'hde,8'h9a,8'h8f,8'h87,8'hd7,8'h3a,8'h80,8'h6f,8'h2f,8'hc8,
        8'hb1,8'hb4,8'h37,8'hf7,8'h0a,8'h22,8'h13,8'h28,8'h7c,8'hcc,8'h3c,8'h89,8'hc7,8'hc3,8'h96,8'h56,
        8'h07,8'hbf,8'h7e,8'hf0,8'h0b,8'h2b,8'h97,8'h52,8'h35,8'h41,8'h79,8'h61,8'ha6,8'h4c,8'h10,8'hfe,
        8'hbc,8'h26,8'h95,8'h88,8'h8a,8'hb0,8'ha3,8'hfb,8'hc0,8'h18,8'h94,8'hf2,8'he1,8'he5,8'he9,8'h5d,
        8'hd0,8'hdc,8'h11,8'h66,8'h64,8'h5c,8'hec,8'h59,8'h42,8'h75,8'h12,8'hf5,8'h74,8'h9c,8'haa,8'h23,
        8'h0e,8'h86,8'hab,8'hbe,8'h2a,8'h02,8'he7,8'h67,8'he6,8'h44,8'ha2,8'h6c,8'hc2,8'h93,8'h9f,8'hf1,
        8'hf6,8'hfa,8'h36,8'hd2,8'h50,8'h68,8'h9e,8'h62,8'h71,8'h15,8'h3d,8'hd6,8'h40,8'hc4,8'he2,8'h0f,
        8'h8e,8'h83,8'h77,8'h6b,8'h25,8'h05,8'h3f,8'h0c,8'h30,8'hea,8'h70,8'hb7,8'ha1,8'he8,8'ha9,8'h65,
        8'h8d,8'h27,8'h1a,8'hdb,8'h81,8'hb3,8'ha0,8'hf4,8'h45,8'h7a,8'h19,8'hdf,8'hee,8'h78,8'h34,8'h60
    };

    localparam logic [7:0] SBOX1 [256] = '{
        8'h55,8'hc2,8'h63,8'h71,8'h3b,8'hc8,8'h47,8'h86,8'h9f,8'h3c,8'hda,8'h5b,8'h29,8'haa,8'hfd,8'h77,
        8'h8c,8'hc5,8'h94,8'h0c,8'ha6,8'h1a,8'h13,8'h00,8'he3,8'ha8,8'h16,8'h72,8'h40,8'hf9,8'hf8,8'h42,
        8'h44,8'h26,8'h68,8'h96,8'h81,8'hd9,8'h45,8'h3e,8'h10,8'h76,8'hc6,8'ha7,8'h8b,8'h39,8'h43,8'he1,
        8'h3a,8'hb5,8'h56,8'h2a,8'hc0,8'h6d,8'hb3,8'h05,8'h22,8'h66,8'hbf,8'hdc,8'h0b,8'hfa,8'h62,8'h48,
        8'hdd,8'h20,8'h11,8'h06,8'h36,8'hc9,8'hc1,8'hcf,8'hf6,8'h27,8'h52,8'hbb,8'h69,8'hf5,8'hd4,8'h87,
        8'h7f,8'h84,8'h4c,8'hd2,8'h9c,8'h57,8'ha4,8'hbc,8'h4f,8'h9a,8'hdf,8'hfe,8'hd6,8'h8d,8'h7a,8'heb,
        8'h2b,8'h53,8'hd8,8'h5c,8'ha1,8'h14,8'h17,8'hfb,8'h23,8'hd5,8'h7d,8'h30,8'h67,8'h73,8'h08,8'h09,
        8'hee,8'hb7,8'h70,8'h3f,8'h61,8'hb2,8'h19,8'h8e,8'h4e,8'he5,8'h4b,8'h93,8'h8f,8'h5d,8'hdb,8'ha9,
        8'had,8'hf1,8'hae,8'h2e,8'hcb,8'h0d,8'hfc,8'hf4,8'h2d,8'h46,8'h6e,8'h1d,8'h97,8'he8,8'hd1,8'he9,
        8'h4d,8'h37,8'ha5,8'h75,8'h5e,8'h83,8'h9e,8'hab,8'h82,8'h9d,8'hb9,8'h1c,8'he0,8'hcd,8'h49,8'h89,
        8'h01,8'hb6,8'hbd,8'h58,8'h24,8'ha2,8'h5f,8'h38,8'h78,8'h99,8'h15,8'h90,8'h50,8'hb8,8'h95,8'he4,
        8'hd0,8'h91,8'hc7,8'hce,8'hed,8'h0f,8'hb4,8'h6f,8'ha0,8'hcc,8'hf0,8'h02,8'h4a,8'h79,8'hc3,8'hde,
        8'ha3,8'hef,8'hea,8'h51,8'he6,8'h6b,8'h18,8'hec,8'h1b,8'h2c,8'h80,8'hf7,8'h74,8'he7,8'hff,8'h21,
        8'h5a,8'h6a,8'h54,8'h1e,8'h41,8'h31,8'h92,8'h35,8'hc4,8'h33,8'h07,8'h0a,8'hba,8'h7e,8'h0e,8'h34,
        8'h88,8'hb1,8'h98,8'h7c,8'hf3,8'h3d,8'h60,8'h6c,8'h7b,8'hca,8'hd3,8'h1f,8'h32,8'h65,8'h04,8'h28,
        8'h64,8'hbe,8'h85,8'h9b,8'h2f,8'h59,8'h8a,8'hd7,8'hb0,8'h25,8'hac,8'haf,8'h12,8'h03,8'he2,8'hf2
    };

    // a + b mod 2^31-1; the end-around carry never overflows 31 bits
    function automatic t_cell add_mod31(input t_cell a, input t_cell b);
        logic [31:0] c;
        c = {1'b0, a} + {1'b0, b};
        return c[30:0] + {30'd0, c[31]};
    endfunction

    function automatic t_cell rot31(input t_cell x, input int k);
        logic [61:0] d;
        d = {x, x} << k;
        return d[61:31];
    endfunction

    function automatic logic [31:0] lin1(input logic [31:0] x);
        return x ^ {x[29:0], x[31:30]} ^ {x[21:0], x[31:22]}
                 ^ {x[13:0], x[31:14]} ^ {x[7:0], x[31:8]};
    endfunction

    function automatic logic [31:0] lin2(input logic [31:0] x);
        return x ^ {x[23:0], x[31:24]} ^ {x[17:0], x[31:18]}
                 ^ {x[9:0], x[31:10]} ^ {x[1:0], x[31:2]};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        return {SBOX0[x[31:24]], SBOX1[x[23:16]], SBOX0[x[15:8]], SBOX1[x[7:0]]};
    endfunction

endpackage

// File: hdl/zuc_lfsr.sv
// LFSR cell bank of the ZUC-128 keystream generator, with its one shared
// mod 2^31-1 adder that folds the feedback terms in turn.
// Depends on zuc_pkg.
module zuc_lfsr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  zuc_pkg::t_lfsr_ctl i_ctl,
    input  logic [127:0]       i_key,
    input  logic [127:0]       i_iv,
    input  zuc_pkg::t_cell     i_extra,
    output zuc_pkg::t_cells    o_cells
);

    zuc_pkg::t_cells r_cells;
    zuc_pkg::t_cell  r_acc;
    zuc_pkg::t_cell  term;
    zuc_pkg::t_cell  addend;
    zuc_pkg::t_cell  sum;
    zuc_pkg::t_cells n_cells_load;

    always_comb begin
        unique case (i_ctl.tap)
            zuc_pkg::TAP_C0:  term = zuc_pkg::rot31(r_cells[0], 8);
            zuc_pkg::TAP_C4:  term = zuc_pkg::rot31(r_cells[4], 20);
            zuc_pkg::TAP_C10: term = zuc_pkg::rot31(r_cells[10], 21);
            zuc_pkg::TAP_C13: term = zuc_pkg::rot31(r_cells[13], 17);
            zuc_pkg::TAP_C15: term = zuc_pkg::rot31(r_cells[15], 15);
            default:          term = '0;
        endcase
    end

    assign addend = i_ctl.feed ? i_extra : term;
    assign sum    = zuc_pkg::add_mod31(r_acc, addend);

    // key byte, constant d, IV byte; byte 0 sits in the top bits
    always_comb begin
        for (int i = 0; i < zuc_pkg::NUM_CELLS; i++) begin
            n_cells_load[i] = {i_key[127 - 8*i -: 8], zuc_pkg::DCONST[i], i_iv[127 - 8*i -: 8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= '0;
        end else if (i_ctl.load) begin
            r_cells <= n_cells_load;
        end else if (i_ctl.feed) begin
            r_cells <= {sum, r_cells[15:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= r_cells[0];
        end else if (i_ctl.add) begin
            r_acc <= sum;
        end
    end

    assign o_cells = r_cells;

endmodule

// File: hdl/zuc_nlf.sv
// Bit reorganisation and nonlinear function F of the ZUC-128 keystream generator.
// Holds R1, R2 and the last W; depends on zuc_pkg.
module zuc_nlf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zuc_pkg::t_nlf_ctl i_ctl,
    input  zuc_pkg::t_cells   i_cells,
    output logic [31:0]       o_w,
    output logic [31:0]       o_word
);

    logic [31:0] r_r1;
    logic [31:0] r_r2;
    logic [31:0] r_w;
    logic [31:0] x0, x1, x2, x3;
    logic [31:0] w, w1, w2;
    logic [31:0] n_r1, n_r2;

    assign x0 = {i_cells[15][30:15], i_cells[14][15:0]};
    assign x1 = {i_cells[11][15:0],  i_cells[9][30:15]};
    assign x2 = {i_cells[7][15:0],   i_cells[5][30:15]};
    assign x3 = {i_cells[2][15:0],   i_cells[0][30:15]};

    assign w    = (x0 ^ r_r1) + r_r2;
    assign w1   = r_r1 + x1;
    assign w2   = r_r2 ^ x2;
    assign n_r1 = zuc_pkg::sub_word(zuc_pkg::lin1({w1[15:0], w2[31:16]}));
    assign n_r2 = zuc_pkg::sub_word(zuc_pkg::lin2({w2[15:0], w1[31:16]}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1 <= '0;
            r_r2 <= '0;
        end else if (i_ctl.clear) begin
            r_r1 <= '0;
            r_r2 <= '0;
        end else if (i_ctl.step) begin
            r_r1 <= n_r1;
            r_r2 <= n_r2;
        end
    end

    // hold W for the feedback step of an initialisation round
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_w <= w;
        end
    end

    assign o_w    = r_w;
    assign o_word = w ^ x3;

endmodule

// File: hdl/zuc_keystream_generator_top.sv
// ZUC-128 keystream generator. A generate request loads its first word into the
// output register on its first F step; each word takes one F step, five tap folds
// and one feedback fold through the single mod 2^31-1 adder, and an F step waits
// while the output register holds an untaken word. An init request runs 33 rounds
// and emits nothing. The block takes no request while a run is in progress.
// Reset (i_rst_n low, synchronous) clears key, IV, LFSR cells, R1 and R2.
module zuc_keystream_generator_top #(
    parameter int MAX_WORDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] word_count, [7] zero
    input  logic        s_axis_tuser,   // [0] opcode
    // keystream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] keystream_word
    output logic        m_axis_tlast
);

    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam logic [6:0] MAX_WC = 7'(MAX_WORDS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FUNC = 4'b0010,
        S_ACC  = 4'b0100,
        S_FEED = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [63:0]   r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic          r_init;
    logic [5:0]    r_round;
    logic [CW-1:0] r_left;
    zuc_pkg::t_tap r_tap;

    logic          r_m_valid;
    logic [31:0]   r_m_data;
    logic          r_m_last;

    zuc_pkg::t_lfsr_ctl lfsr_ctl;
    zuc_pkg::t_nlf_ctl  nlf_ctl;
    zuc_pkg::t_cells    cells;
    zuc_pkg::t_cell     extra;
    logic [31:0]        nlf_w;
    logic [31:0]        nlf_word;

    logic          req_acc;
    logic          out_free;
    logic          func_go;
    logic [6:0]    wc_sat;
    logic [CW-1:0] wc_cnt;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign req_acc       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign func_go       = (r_state == S_FUNC) && (r_init || out_free);

    assign wc_sat = (s_axis_tdata[6:0] > MAX_WC) ? MAX_WC : s_axis_tdata[6:0];
    assign wc_cnt = wc_sat[CW-1:0];

    // fold W >> 1 in the 32 init rounds; the discard round folds zero
    assign extra = (r_init && r_round != zuc_pkg::INIT_ROUNDS) ? nlf_w[31:1] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (zuc_pkg::t_cfg_reg'(i_cfg_index))
                zuc_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                zuc_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                zuc_pkg::CFG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                zuc_pkg::CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                default:               r_iv_low   <= r_iv_low;
            endcase
        end
    end

    always_comb begin
        n_state        = r_state;
        lfsr_ctl       = '0;
        lfsr_ctl.tap   = r_tap;
        nlf_ctl        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (s_axis_tuser == zuc_pkg::OP_INIT) begin
                        lfsr_ctl.load = 1'b1;
                        nlf_ctl.clear = 1'b1;
                        n_state       = S_FUNC;
                    end else if (wc_cnt != '0) begin
                        n_state = S_FUNC;
                    end
                end
            end
            S_FUNC: begin
                if (func_go) begin
                    nlf_ctl.step   = 1'b1;
                    lfsr_ctl.start = 1'b1;
                    n_state        = S_ACC;
                end
            end
            S_ACC: begin
                lfsr_ctl.add = 1'b1;
                if (r_tap == zuc_pkg::TAP_C15) begin
                    n_state = S_FEED;
                end
            end
            S_FEED: begin
                lfsr_ctl.feed = 1'b1;
                if (r_init) begin
                    n_state = (r_round == zuc_pkg::INIT_ROUNDS) ? S_IDLE : S_FUNC;
                end else begin
                    n_state = (r_left == CW'(1)) ? S_IDLE : S_FUNC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_init  <= 1'b0;
            r_round <= '0;
            r_left  <= '0;
            r_tap   <= zuc_pkg::TAP_C0;
        end else begin
            r_state <= n_state;
            if (req_acc) begin
                r_init  <= (s_axis_tuser == zuc_pkg::OP_INIT);
                r_round <= '0;
                r_left  <= wc_cnt;
            end
            if (func_go) begin
                r_tap <= zuc_pkg::TAP_C0;
            end else if (r_state == S_ACC) begin
                r_tap <= zuc_pkg::t_tap'(r_tap + 3'd1);
            end
            if (r_state == S_FEED) begin
                if (r_init) begin
                    r_round <= r_round + 6'd1;
                end else begin
                    r_left <= r_left - CW'(1);
                end
            end
        end
    end

    // output register: load a word on the F cycle of a generate round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (func_go && !r_init) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (func_go && !r_init) begin
            r_m_data <= nlf_word;
            r_m_last <= (r_left == CW'(1));
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    zuc_lfsr u_lfsr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lfsr_ctl),
        .i_key   ({r_key_high, r_key_low}),
        .i_iv    ({r_iv_high, r_iv_low}),
        .i_extra (extra),
        .o_cells (cells)
    );

    zuc_nlf u_nlf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (nlf_ctl),
        .i_cells (cells),
        .o_w     (nlf_w),
        .o_word  (nlf_word)
    );

endmodule

// File: hdl/zuc_chk.sv
// Port-level checks for the ZUC-128 keystream generator top level.
// Bound to zuc_keystream_generator_top; no package dependencies.
module zuc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled word holds
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("keystream word changed while stalled");

    // no word is shown straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("word valid after reset");

    // an init request keeps the block busy and produces no word
    a_init_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid
        |=> !m_axis_tvalid && !s_axis_tready)
        else $error("init request produced a word or freed the input");

    // a run still has words to deliver after a non-final word is taken
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
        else $error("request taken in the middle of a keystream run");

endmodule

bind zuc_keystream_generator_top zuc_chk u_zuc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: verif/zuc_keystream_generator_top_test.sv
// Self-checking testbench for zuc_keystream_generator_top: init and generate requests
// are streamed in, each keystream word is checked against an in-bench ZUC-128 predictor.
// Depends on zuc_pkg for the opcode and register index codes.
module zuc_keystream_generator_top_test;

    localparam int          WORD_CAP     = 64;
    localparam int          RANDOM_ITEMS = 390;
    localparam int          SETTLE       = 300;       // covers an init request
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          HOLD_AFTER   = 700;
    localparam int          HOLD_CYCLES  = 500;

    localparam logic [0:255][7:0] S0_LUT = {
        128'h3e725b47cae0003304d1549809b96dcb, 128'h7b1bf932af9d6aa5b82dfc1d08530390,
        128'h4d4e8499e4ced991ddb685488b296eac, 128'hcdc1f81e734369c6b5bdfd396320d438,
        128'h767db2a7cfed57c5f32cbb142106559b, 128'he3ef5e314f7f5aa40d8251495fba581c,
        128'h4a16d517a892241f8cffd8ae2e01d3ad, 128'h3b4bda46ebc9de9a8f87d73a806f2fc8,
        128'hb1b437f70a2213287ccc3c89c7c39656, 128'h07bf7ef00b2b975235417961a64c10fe,
        128'hbc2695888ab0a3fbc01894f2e1e5e95d, 128'hd0dc1166645cec59427512f5749caa23,
        128'h0e86abbe2a02e767e644a26cc2939ff1, 128'hf6fa36d250689e6271153dd640c4e20f,
        128'h8e83776b25053f0c30ea70b7a1e8a965, 128'h8d271adb81b3a0f4457a19dfee783460
    };

    localparam logic [0:255][7:0] S1_LUT = {
        128'h55c263713bc847869f3cda5b29aafd77, 128'h8cc5940ca61a1300e3a8167240f9f842,
        128'h4426689681d9453e1076c6a78b3943e1, 128'h3ab5562ac06db3052266bfdc0bfa6248,
        128'hdd20110636c9c1cff62752bb69f5d487, 128'h7f844cd29c57a4bc4f9adffed68d7aeb,
        128'h2b53d85ca11417fb23d57d3067730809, 128'heeb7703f61b2198e4ee54b938f5ddba9,
        128'hadf1ae2ecb0dfcf42d466e1d97e8d1e9, 128'h4d37a5755e839eab829db91ce0cd4989,
        128'h01b6bd5824a25f387899159050b895e4, 128'hd091c7ceed0fb46fa0ccf0024a79c3de,
        128'ha3efea51e66b18ec1b2c80f774e7ff21, 128'h5a6a541e41319235c433070aba7e0e34,
        128'h88b1987cf33d606c7bcad31f32650428, 128'h64be859b2f598ad7b025acaf1203e2f2
    };

    localparam logic [0:15][14:0] LOAD_D = {
        15'h44D7, 15'h26BC, 15'h626B, 15'h135E, 15'h5789, 15'h35E2, 15'h7135, 15'h09AF,
        15'h4D78, 15'h2F13, 15'h6BC4, 15'h1AF1, 15'h5E26, 15'h3C4D, 15'h789A, 15'h47AC
    };

    typedef struct packed {
        logic       opcode;
        logic [6:0] count;
    } t_request;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_ks_word;

    typedef logic [63:0] t_reg_set [4];

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = 2'd0;
    logic [63:0] i_cfg_data    = 64'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    // predictor state
    logic [30:0] lfsr_reg [16];
    logic [31:0] r1_reg;
    logic [31:0] r2_reg;
    logic [63:0] cfg_regs [4];

    t_request    request_q [$];
    t_ks_word    keystream_q [$];

    logic        no_gaps     = 1'b0;
    int          error_count = 0;
    int          words_seen  = 0;
    int          hold_left   = 0;
    logic        hold_done   = 1'b0;
    int unsigned cycle_count = 0;

    zuc_keystream_generator_top #(
        .MAX_WORDS (WORD_CAP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [30:0] mod_add(input logic [30:0] a, input logic [30:0] b);
        logic [31:0] s;
        s = a + b;
        // fold the carry back in: 2^31 == 1 modulo 2^31-1
        return s[30:0] + s[31];
    endfunction

    function automatic logic [30:0] rot_cell(input logic [30:0] x, input int k);
        return (x << k) | (x >> (31 - k));
    endfunction

    function automatic logic [31:0] rot_word(input logic [31:0] x, input int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] sbox_layer(input logic [31:0] x);
        return {S0_LUT[x[31:24]], S1_LUT[x[23:16]], S0_LUT[x[15:8]], S1_LUT[x[7:0]]};
    endfunction

    // bit reorganisation and F; advances R1/R2, returns W
    function automatic logic [31:0] f_round(output logic [31:0] x3);
        logic [31:0] x0, x1, x2, w, w1, w2, u, v;
        x0 = {lfsr_reg[15][30:15], lfsr_reg[14][15:0]};
        x1 = {lfsr_reg[11][15:0], lfsr_reg[9][30:15]};
        x2 = {lfsr_reg[7][15:0], lfsr_reg[5][30:15]};
        x3 = {lfsr_reg[2][15:0], lfsr_reg[0][30:15]};
        w  = (x0 ^ r1_reg) + r2_reg;
        w1 = r1_reg + x1;
        w2 = r2_reg ^ x2;
        u  = {w1[15:0], w2[31:16]};
        v  = {w2[15:0], w1[31:16]};
        r1_reg = sbox_layer(u ^ rot_word(u, 2) ^ rot_word(u, 10) ^ rot_word(u, 18)
                            ^ rot_word(u, 24));
        r2_reg = sbox_layer(v ^ rot_word(v, 8) ^ rot_word(v, 14) ^ rot_word(v, 22)
                            ^ rot_word(v, 30));
        return w;
    endfunction

    function automatic void lfsr_advance(input logic [30:0] extra);
        logic [30:0] fb;
        fb = lfsr_reg[0];
        fb = mod_add(fb, rot_cell(lfsr_reg[0], 8));
        fb = mod_add(fb, rot_cell(lfsr_reg[4], 20));
        fb = mod_add(fb, rot_cell(lfsr_reg[10], 21));
        fb = mod_add(fb, rot_cell(lfsr_reg[13], 17));
        fb = mod_add(fb, rot_cell(lfsr_reg[15], 15));
        fb = mod_add(fb, extra);
        for (int i = 0; i < 15; i++)
            lfsr_reg[i] = lfsr_reg[i + 1];
        lfsr_reg[15] = fb;
    endfunction

    // apply one accepted request and queue the words it must produce
    function automatic void compute_keystream(input logic opcode, input logic [6:0] count);
        logic [127:0] key, iv;
        logic [31:0]  w, x3;
        int           n;
        key = {cfg_regs[zuc_pkg::CFG_KEY_HIGH], cfg_regs[zuc_pkg::CFG_KEY_LOW]};
        iv  = {cfg_regs[zuc_pkg::CFG_IV_HIGH], cfg_regs[zuc_pkg::CFG_IV_LOW]};
        if (opcode == zuc_pkg::OP_INIT) begin
            for (int i = 0; i < 16; i++)
                lfsr_reg[i] = {key[127 - 8 * i -: 8], LOAD_D[i], iv[127 - 8 * i -: 8]};
            r1_reg = '0;
            r2_reg = '0;
            for (int i = 0; i < 32; i++) begin
                w = f_round(x3);
                lfsr_advance(w[31:1]);
            end
            // discard one F output, then one work-mode step
            w = f_round(x3);
            lfsr_advance('0);
        end else begin
            n = (count > WORD_CAP) ? WORD_CAP : count;
            for (int i = 0; i < n; i++) begin
                w = f_round(x3);
                keystream_q.push_back('{word: w ^ x3, last: (i == n - 1)});
                lfsr_advance('0);
            end
        end
    endfunction

    function automatic logic [6:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 4)  return 7'd0;
        if (r < 8)  return 7'($urandom_range(65, 127));
        if (r < 16) return 7'($urandom_range(9, 64));
        return 7'($urandom_range(1, 8));
    endfunction

    function automatic void queue_request(input logic opcode, input logic [6:0] count);
        request_q.push_back('{opcode: opcode, count: count});
    endfunction

    // drain: nothing pending, nothing in flight, then give a silent run time to finish;
    // sample on the falling edge so the driver and monitor have settled
    task automatic wait_quiet();
        @(negedge i_clk);
        while (request_q.size() != 0 || s_axis_tvalid || keystream_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_registers(input logic [3:0] sel, input t_reg_set vals);
        zuc_pkg::t_cfg_reg idx;
        for (int i = 0; i < 4; i++) begin
            if (sel[i]) begin
                idx = zuc_pkg::t_cfg_reg'(i);
                i_cfg_valid <= 1'b1;
                i_cfg_index <= idx;
                i_cfg_data  <= vals[i];
                @(posedge i_clk);
                while (!o_cfg_ready) @(posedge i_clk);
                cfg_regs[idx] = vals[i];
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                compute_keystream(s_axis_tuser, s_axis_tdata[6:0]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (request_q.size() != 0 && (no_gaps || $urandom_range(99) >= 26)) begin
                    req = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, req.count};
                    s_axis_tuser  <= req.opcode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // keystream monitor and receiver back-pressure
    always @(posedge i_clk) begin
        t_ks_word want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                words_seen <= words_seen + 1;
                if (keystream_q.size() == 0) begin
                    $error("keystream_word: expected nothing, got %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = keystream_q.pop_front();
                    if (m_axis_tdata !== want.word) begin
                        $error("keystream_word: expected %h, got %h", want.word, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_word: expected %b, got %b", want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && (no_gaps || $urandom_range(99) >= 26);
        end
    end

    // hold off the receiver once for a long stretch while requests are still queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && words_seen >= HOLD_AFTER && request_q.size() > 2) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("zuc_keystream_generator_top regression: fail");
            $finish;
        end
    end

    initial begin
        t_reg_set   vals;
        logic [3:0] sel;
        int         issued;
        int         phase;
        int         burst;
        int         flavour;
        for (int i = 0; i < 4; i++)
            cfg_regs[i] = '0;
        for (int i = 0; i < 16; i++)
            lfsr_reg[i] = '0;
        r1_reg = '0;
        r2_reg = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // out of reset: generate from the all-zero state, then init with zero key and IV
        queue_request(zuc_pkg::OP_GEN, 7'd3);
        queue_request(zuc_pkg::OP_GEN, 7'd0);
        queue_request(zuc_pkg::OP_INIT, 7'd127);
        queue_request(zuc_pkg::OP_GEN, 7'd1);
        queue_request(zuc_pkg::OP_GEN, 7'd64);
        queue_request(zuc_pkg::OP_GEN, 7'd65);
        queue_request(zuc_pkg::OP_GEN, 7'd127);
        queue_request(zuc_pkg::OP_GEN, 7'd2);
        wait_quiet();

        vals = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        write_registers(4'hF, vals);
        queue_request(zuc_pkg::OP_INIT, 7'd0);
        queue_request(zuc_pkg::OP_GEN, 7'd0);
        queue_request(zuc_pkg::OP_GEN, 7'd5);
        queue_request(zuc_pkg::OP_GEN, 7'd64);
        wait_quiet();

        vals = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
        write_registers(4'hF, vals);
        queue_request(zuc_pkg::OP_GEN, 7'd4);
        queue_request(zuc_pkg::OP_INIT, 7'd64);
        queue_request(zuc_pkg::OP_GEN, 7'd8);
        queue_request(zuc_pkg::OP_GEN, 7'd1);
        queue_request(zuc_pkg::OP_INIT, 7'd1);
        queue_request(zuc_pkg::OP_GEN, 7'd3);

        issued = 0;
        phase  = 0;
        while (issued < RANDOM_ITEMS) begin
            wait_quiet();
            no_gaps <= (phase >= 4 && phase < 10);
            flavour = $urandom_range(9);
            for (int i = 0; i < 4; i++)
                vals[i] = (flavour == 0) ? 64'd0 :
                          (flavour == 1) ? {64{1'b1}} : {$urandom, $urandom};
            sel = ($urandom_range(3) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
            write_registers(sel, vals);
            // mostly a fresh init followed by a burst; sometimes carry on from the old state
            if ($urandom_range(99) < 85) begin
                queue_request(zuc_pkg::OP_INIT, 7'($urandom_range(127)));
                issued++;
            end
            burst = $urandom_range(3, 12);
            repeat (burst) begin
                if ($urandom_range(99) < 8)
                    queue_request(zuc_pkg::OP_INIT, 7'($urandom_range(127)));
                else
                    queue_request(zuc_pkg::OP_GEN, pick_count());
            end
            issued += burst;
            phase++;
        end
        wait_quiet();

        if (error_count == 0)
            $display("zuc_keystream_generator_top regression: pass");
        else
            $display("zuc_keystream_generator_top regression: fail");
        $finish;
    end

endmodule
